/* sv/ptw_pkg.sv */
// ----------------------------------------------------------------------------
// ptw_pkg
// Types and constants shared by the four-level page table walker.
// ----------------------------------------------------------------------------
package ptw_pkg;

   localparam int PHYS_ADDR_BITS = 52;
   localparam int ADDR_W         = 52;
   localparam int VA_W           = 48;
   localparam int ENTRY_W        = 64;
   localparam int PAGE_BITS      = 12;
   localparam int INDEX_W        = 9;

   localparam logic [63:0] PHYS_MASK_64 = (64'd1 << PHYS_ADDR_BITS) - 64'd1;
   localparam logic [ADDR_W-1:0] PHYS_MASK     = PHYS_MASK_64[ADDR_W-1:0];
   localparam logic [ADDR_W-1:0] GIB_OFFSET    = ADDR_W'(64'h3FFF_FFFF);
   localparam logic [ADDR_W-1:0] MIB2_OFFSET   = ADDR_W'(64'h1F_FFFF);
   localparam logic [ADDR_W-1:0] PAGE_LOW_MASK = ADDR_W'(64'hFFF);
   localparam logic [ADDR_W-1:0] FRAME_MASK    = PHYS_MASK & ~PAGE_LOW_MASK;
   localparam int LARGE_BIT   = 7;
   localparam int PRESENT_BIT = 0;

   localparam logic ACTION_START    = 1'b0;
   localparam logic ACTION_RESPONSE = 1'b1;
   localparam logic KIND_READ       = 1'b0;
   localparam logic KIND_DONE       = 1'b1;

   localparam logic [1:0] LEVEL_PML4 = 2'd0;
   localparam logic [1:0] LEVEL_PDPT = 2'd1;
   localparam logic [1:0] LEVEL_PD   = 2'd2;
   localparam logic [1:0] LEVEL_PT   = 2'd3;

   typedef struct packed {
      logic               action;
      logic [ADDR_W-1:0]  table_base;
      logic [VA_W-1:0]    virt_addr;
      logic [ENTRY_W-1:0] entry_data;
      logic               read_ok;
   } req_type;

   typedef struct packed {
      logic              result_kind;
      logic [ADDR_W-1:0] request_address;
      logic [ADDR_W-1:0] phys_addr;
      logic              fault;
      logic [1:0]        fault_level;
   } rsp_type;

   typedef struct packed {
      logic            busy;
      logic [1:0]      level;
      logic [VA_W-1:0] held_va;
   } walk_state_type;

   typedef struct packed {
      logic           emit;
      walk_state_type state;
      rsp_type        rsp;
   } step_type;

endpackage

/* sv/four_level_page_table_walker.sv */
// ----------------------------------------------------------------------------
// four_level_page_table_walker
// Four-level page table walker: issues one entry read per level and reports
// the translated address or a fault.
// ----------------------------------------------------------------------------
// Usage:
//   req channel: a transaction with action = start carries table_base and
//   the virtual address; one with action = response carries entry_data and
//   read_ok for the entry read last requested.
//   rsp channel: result_kind = read asks for the 8-byte entry at
//   request_address; result_kind = done ends the walk with the translated
//   address or fault and fault_level.
//   Each req transaction yields at most one rsp transaction (a response
//   while no walk is running yields none) in the cycle after acceptance,
//   from an output register. A start while a walk runs abandons that walk.
//   Throughput is one req transaction per cycle unless the receiver stalls:
//   the step logic sits between the walk state registers and the output
//   register. When the receiver stalls, the output register holds its
//   transaction and req_ready drops until it is taken.
//   Reset leaves the walker idle, with no result pending.
// ----------------------------------------------------------------------------
module four_level_page_table_walker
   import ptw_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_ready,
   input  req_type req_payload,
   output logic    rsp_valid,
   input  logic    rsp_ready,
   output rsp_type rsp_payload
);

   walk_state_type state_ff, state_in;
   logic           rsp_valid_ff, rsp_valid_in;
   rsp_type        rsp_ff, rsp_in;
   step_type       step;
   logic           accept;

   ptw_step u_step (
      .cur  (state_ff),
      .req  (req_payload),
      .step (step)
   );

   assign req_ready   = !rsp_valid_ff || rsp_ready;
   assign accept      = req_valid && req_ready;
   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_ff;

   always_comb begin
      state_in     = state_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_in       = rsp_ff;
      if (accept) begin
         state_in = step.state;
         if (step.emit) begin
            rsp_valid_in = 1'b1;
            rsp_in       = step.rsp;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_ff <= rsp_in;
   end

endmodule

/* sv/ptw_step.sv */
// ----------------------------------------------------------------------------
// ptw_step
// One walk step: from the current walk state and one transaction, the next
// state and the result, if any.
// ----------------------------------------------------------------------------
module ptw_step
   import ptw_pkg::*;
(
   input  walk_state_type cur,
   input  req_type        req,
   output step_type       step
);

   logic [1:0]         next_level;
   logic [INDEX_W-1:0] index;
   logic [ADDR_W-1:0]  entry_phys;
   logic               big_page;

   assign next_level = cur.level + 2'd1;
   assign entry_phys = req.entry_data[ADDR_W-1:0] & PHYS_MASK;
   assign big_page   = req.entry_data[LARGE_BIT];

   always_comb begin
      logic [VA_W-1:0] va;
      logic [1:0]      lvl;
      va  = (req.action == ACTION_START) ? req.virt_addr : cur.held_va;
      lvl = (req.action == ACTION_START) ? LEVEL_PML4 : next_level;
      unique case (lvl)
         LEVEL_PML4: index = va[47:39];
         LEVEL_PDPT: index = va[38:30];
         LEVEL_PD:   index = va[29:21];
         LEVEL_PT:   index = va[20:12];
         default:    index = va[47:39];
      endcase
   end

   always_comb begin
      step                      = '0;
      step.state                = cur;
      step.rsp.result_kind      = KIND_DONE;
      step.rsp.fault_level      = cur.level;
      if (req.action == ACTION_START) begin
         step.emit = 1'b1;
         if (req.table_base == '0) begin
            step.state.busy  = 1'b0;
            step.state.level = LEVEL_PML4;
            step.rsp.fault   = 1'b1;
            step.rsp.fault_level = LEVEL_PML4;
         end else begin
            step.state.busy    = 1'b1;
            step.state.level   = LEVEL_PML4;
            step.state.held_va = req.virt_addr;
            step.rsp.result_kind     = KIND_READ;
            step.rsp.fault_level     = LEVEL_PML4;
            step.rsp.request_address = (req.table_base & FRAME_MASK)
                                     | ADDR_W'({index, 3'b000});
         end
      end else if (cur.busy) begin
         step.emit = 1'b1;
         priority if (!req.read_ok || !req.entry_data[PRESENT_BIT]) begin
            step.state.busy = 1'b0;
            step.rsp.fault  = 1'b1;
         end else if (cur.level == LEVEL_PDPT && big_page) begin
            step.state.busy = 1'b0;
            step.rsp.phys_addr = (entry_phys & ~GIB_OFFSET)
                               | (ADDR_W'(cur.held_va) & GIB_OFFSET);
         end else if (cur.level == LEVEL_PD && big_page) begin
            step.state.busy = 1'b0;
            step.rsp.phys_addr = (entry_phys & ~MIB2_OFFSET)
                               | (ADDR_W'(cur.held_va) & MIB2_OFFSET);
         end else if (cur.level == LEVEL_PT) begin
            step.state.busy = 1'b0;
            step.rsp.phys_addr = (entry_phys & FRAME_MASK)
                               | (ADDR_W'(cur.held_va) & PAGE_LOW_MASK);
         end else begin
            step.state.level         = next_level;
            step.rsp.result_kind     = KIND_READ;
            step.rsp.fault_level     = next_level;
            step.rsp.request_address = (entry_phys & FRAME_MASK)
                                     | ADDR_W'({index, 3'b000});
         end
      end
   end

endmodule

/* dv/four_level_page_table_walker_test.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// four_level_page_table_walker_test
// Drives table walks into the walker: starts, entry responses at every level,
// large pages, faults, abandoned walks and stray responses. A scoreboard
// predicts each read request and walk result and checks them in order.
// ----------------------------------------------------------------------------
module four_level_page_table_walker_test;
   import ptw_pkg::*;

   class walk_scoreboard;
      bit                walk_active;
      logic [1:0]        walk_depth;
      logic [VA_W-1:0]   walk_va;
      rsp_type           pending_walk_results[$];
      int                mismatches;

      function new();
         walk_active = 1'b0;
         walk_depth  = LEVEL_PML4;
         walk_va     = '0;
         mismatches  = 0;
      endfunction

      function logic [ADDR_W-1:0] entry_offset(logic [VA_W-1:0] va, logic [1:0] lvl);
         logic [VA_W-1:0] shifted;
         shifted = va >> (39 - 9 * int'(lvl));
         return ADDR_W'(shifted[INDEX_W-1:0]) << 3;
      endfunction

      function void note_request(req_type t);
         rsp_type           r;
         logic [ADDR_W-1:0] frame;
         logic [ADDR_W-1:0] va_ext;
         r      = '0;
         frame  = t.entry_data[ADDR_W-1:0];
         va_ext = ADDR_W'(walk_va);
         if (t.action == ACTION_START) begin
            if (t.table_base == '0) begin
               walk_active   = 1'b0;
               walk_depth    = LEVEL_PML4;
               r.result_kind = KIND_DONE;
               r.fault       = 1'b1;
               r.fault_level = LEVEL_PML4;
            end else begin
               walk_va           = t.virt_addr;
               walk_depth        = LEVEL_PML4;
               walk_active       = 1'b1;
               r.result_kind     = KIND_READ;
               r.request_address = (t.table_base & FRAME_MASK) +
                                   entry_offset(t.virt_addr, LEVEL_PML4);
               r.fault_level     = LEVEL_PML4;
            end
            pending_walk_results.push_back(r);
            return;
         end
         if (!walk_active)
            return;
         r.result_kind = KIND_DONE;
         if (!t.read_ok || !t.entry_data[PRESENT_BIT]) begin
            walk_active   = 1'b0;
            r.fault       = 1'b1;
            r.fault_level = walk_depth;
         end else if (walk_depth == LEVEL_PDPT && t.entry_data[LARGE_BIT]) begin
            walk_active   = 1'b0;
            r.phys_addr   = (frame & PHYS_MASK & ~GIB_OFFSET) | (va_ext & GIB_OFFSET);
            r.fault_level = LEVEL_PDPT;
         end else if (walk_depth == LEVEL_PD && t.entry_data[LARGE_BIT]) begin
            walk_active   = 1'b0;
            r.phys_addr   = (frame & PHYS_MASK & ~MIB2_OFFSET) | (va_ext & MIB2_OFFSET);
            r.fault_level = LEVEL_PD;
         end else if (walk_depth == LEVEL_PT) begin
            walk_active   = 1'b0;
            r.phys_addr   = (frame & FRAME_MASK) | (va_ext & PAGE_LOW_MASK);
            r.fault_level = LEVEL_PT;
         end else begin
            walk_depth        = walk_depth + 2'd1;
            r.result_kind     = KIND_READ;
            r.request_address = (frame & FRAME_MASK) + entry_offset(walk_va, walk_depth);
            r.fault_level     = walk_depth;
         end
         pending_walk_results.push_back(r);
      endfunction

      function void compare_field(string name, logic [63:0] want, logic [63:0] got);
         if (want !== got) begin
            mismatches++;
            $display("%0t: %s mismatch, expected %h actual %h", $time, name, want, got);
         end
      endfunction

      function void check_result(rsp_type r);
         rsp_type want;
         if (pending_walk_results.size() == 0) begin
            mismatches++;
            $display("%0t: unexpected transaction, expected none actual %h", $time, r);
            return;
         end
         want = pending_walk_results.pop_front();
         compare_field("result_kind", 64'(want.result_kind), 64'(r.result_kind));
         compare_field("request_address", 64'(want.request_address),
                       64'(r.request_address));
         compare_field("phys_addr", 64'(want.phys_addr), 64'(r.phys_addr));
         compare_field("fault", 64'(want.fault), 64'(r.fault));
         compare_field("fault_level", 64'(want.fault_level), 64'(r.fault_level));
      endfunction
   endclass

   logic    clock = 1'b0;
   logic    reset;
   logic    req_valid;
   logic    req_ready;
   req_type req_payload;
   logic    rsp_valid;
   logic    rsp_ready;
   rsp_type rsp_payload;

   walk_scoreboard sb = new();
   bit             quiet;
   int             walk_items;

   four_level_page_table_walker uut (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_payload (req_payload),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_payload (rsp_payload)
   );

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   always @(posedge clock) begin
      if (!reset && req_valid && req_ready)
         sb.note_request(req_payload);
      if (!reset && rsp_valid && rsp_ready)
         sb.check_result(rsp_payload);
   end

   initial begin
      rsp_ready = 1'b0;
      @(negedge reset);
      forever begin
         @(negedge clock);
         if (!quiet && $urandom_range(7, 0) == 0) begin
            rsp_ready = 1'b0;
            repeat ($urandom_range(7, 0)) @(negedge clock);
         end else begin
            rsp_ready = 1'b1;
         end
      end
   end

   function automatic logic [63:0] rand64();
      return {$urandom(), $urandom()};
   endfunction

   task automatic send_item(req_type t);
      if (!quiet && $urandom_range(5, 0) == 0) begin
         req_valid = 1'b0;
         repeat ($urandom_range(8, 1)) @(negedge clock);
      end
      req_payload = t;
      req_valid   = 1'b1;
      do @(posedge clock); while (!req_ready);
      @(negedge clock);
   endtask

   task automatic send_start(logic [ADDR_W-1:0] base, logic [VA_W-1:0] va);
      req_type t;
      t.action     = ACTION_START;
      t.table_base = base;
      t.virt_addr  = va;
      t.entry_data = rand64();
      t.read_ok    = 1'($urandom_range(1, 0));
      send_item(t);
   endtask

   task automatic send_entry(logic [ENTRY_W-1:0] entry, logic ok);
      req_type t;
      t.action     = ACTION_RESPONSE;
      t.table_base = ADDR_W'(rand64());
      t.virt_addr  = VA_W'(rand64());
      t.entry_data = entry;
      t.read_ok    = ok;
      send_item(t);
   endtask

   task automatic wait_drained();
      while (sb.pending_walk_results.size() != 0) @(negedge clock);
   endtask

   task automatic random_walk();
      logic [ADDR_W-1:0]  base;
      logic [ENTRY_W-1:0] entry;
      logic               ok;
      base = ADDR_W'(rand64());
      if ($urandom_range(24, 0) == 0)
         base = '0;
      if ($urandom_range(19, 0) == 0)
         send_entry(rand64(), 1'($urandom_range(1, 0)));
      send_start(base, VA_W'(rand64()));
      walk_items++;
      if (base == '0)
         return;
      for (int lvl = 0; lvl < 4; lvl++) begin
         if ($urandom_range(24, 0) == 0)
            return;
         entry    = rand64();
         ok       = ($urandom_range(15, 0) != 0);
         entry[PRESENT_BIT] = ($urandom_range(15, 0) != 0);
         if (lvl == 1 || lvl == 2)
            entry[LARGE_BIT] = ($urandom_range(3, 0) == 0);
         send_entry(entry, ok);
         walk_items++;
         if (!ok || !entry[PRESENT_BIT] || ((lvl == 1 || lvl == 2) && entry[LARGE_BIT]))
            return;
      end
   endtask

   initial begin
      reset       = 1'b1;
      req_valid   = 1'b0;
      req_payload = '0;
      quiet       = 1'b0;
      walk_items  = 0;
      repeat (4) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // stray response while idle, zero base, extremes of base and address
      send_entry('1, 1'b1);
      send_start('0, '1);
      send_start('1, '1);
      send_entry('1, 1'b1);
      send_entry(64'h8000_0000_0000_0001, 1'b1);
      send_entry(64'h7FFF_FFFF_FFFF_FF7F, 1'b1);
      send_entry('1, 1'b1);
      // 1 GiB page
      send_start(52'h1000, '0);
      send_entry('1, 1'b1);
      send_entry('1, 1'b1);
      // 2 MiB page
      send_start(ADDR_W'(rand64()), VA_W'(rand64()));
      send_entry(64'hFFFF_FFFF_FFFF_FF7F, 1'b1);
      send_entry(64'h0000_0000_0000_0001, 1'b1);
      send_entry(64'h0000_0000_0000_0081, 1'b1);
      // faults: not present at the top, read error, abandoned walk, last level
      send_start(ADDR_W'(rand64()), VA_W'(rand64()));
      send_entry(64'hFFFF_FFFF_FFFF_FFFE, 1'b1);
      send_start(ADDR_W'(rand64()), VA_W'(rand64()));
      send_entry(64'h0000_0000_0000_1001, 1'b1);
      send_entry('1, 1'b0);
      send_start(ADDR_W'(rand64()), VA_W'(rand64()));
      send_entry(64'h0000_0000_0000_2001, 1'b1);
      send_start(ADDR_W'(rand64()), VA_W'(rand64()));
      send_entry(64'h0000_0000_0000_3001, 1'b1);
      send_entry(64'h0000_0000_0000_4001, 1'b1);
      send_entry(64'h0000_0000_0000_5001, 1'b1);
      send_entry(64'hFFFF_FFFF_FFFF_FFFE, 1'b1);
      req_valid = 1'b0;
      wait_drained();

      while (walk_items < 1000) begin
         quiet = (walk_items > 900);
         random_walk();
      end
      req_valid = 1'b0;
      wait_drained();
      repeat (10) @(negedge clock);

      if (sb.mismatches == 0 && sb.pending_walk_results.size() == 0)
         $display("Test completed successfully");
      else
         $display("Test completed with failures");
      $finish;
   end

   initial begin
      #5_000_000;
      $display("Test completed with failures");
      $finish;
   end

endmodule

/* four_level_page_table_walker.f */
sv/ptw_pkg.sv
sv/ptw_step.sv
sv/four_level_page_table_walker.sv
dv/four_level_page_table_walker_test.sv
